>>> rtl/core/deq_pkg.sv
// ----------------------------------------------------------------------------
// Double-ended queue package
// Sizes, operation codes and the command word shared by the controller
// and the datapath.
// ----------------------------------------------------------------------------
package deq_pkg;

   localparam int DEPTH      = 64;
   localparam int DATA_WIDTH = 64;
   localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W    = $clog2(DEPTH + 1);
   localparam int SUM_W      = COUNT_W + 1;
   localparam int OP_W       = 3;
   localparam int WORD_W     = 64;

   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [OP_W-1:0] OP_NOP        = 3'd4;

   typedef struct packed {
      logic load;
      logic exec;
      logic fetch;
   } cmd_type;

endpackage

>>> rtl/core/deq_ctrl.sv
// ----------------------------------------------------------------------------
// Double-ended queue controller
// Sequences each word through execute, memory read and response.
// ----------------------------------------------------------------------------
module deq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output logic             rsp_strobe,
   output deq_pkg::cmd_type cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_READ = 2'd2;
   localparam logic [1:0] S_RESP = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign busy       = (state_ff == S_EXEC) || (state_ff == S_READ);
   assign rsp_strobe = (state_ff == S_RESP);

   always_comb begin
      cmd.load  = start && !busy;
      cmd.exec  = (state_ff == S_EXEC);
      cmd.fetch = (state_ff == S_READ);
   end

   always_comb begin
      unique case (state_ff)
         S_IDLE: begin
            state_in = start ? S_EXEC : S_IDLE;
         end
         S_EXEC: begin
            state_in = S_READ;
         end
         S_READ: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            state_in = start ? S_EXEC : S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.exec, cmd.fetch}))
      else $error("controller issued overlapping commands");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.exec)
      else $error("accepted word not executed next cycle");

   a_strobe_after_read: assert property (@(posedge clock) disable iff (reset)
      cmd.fetch |=> rsp_strobe)
      else $error("response strobe did not follow memory read");

endmodule

>>> rtl/core/deq_datapath.sv
// ----------------------------------------------------------------------------
// Double-ended queue datapath
// Ring buffer storage, head pointer, entry count and response registers.
// ----------------------------------------------------------------------------
module deq_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  deq_pkg::cmd_type                  cmd,
   input  logic [deq_pkg::OP_W-1:0]          req_op,
   input  logic [deq_pkg::WORD_W-1:0]        req_push_value,
   output logic [deq_pkg::WORD_W-1:0]        rsp_front_value,
   output logic [deq_pkg::WORD_W-1:0]        rsp_back_value,
   output logic [deq_pkg::COUNT_W-1:0]       rsp_occupancy,
   output logic                              rsp_is_empty,
   output logic                              rsp_is_full,
   output logic                              rsp_op_error
);

   logic [deq_pkg::DATA_WIDTH-1:0] mem [deq_pkg::DEPTH];

   logic [deq_pkg::OP_W-1:0]       op_ff;
   logic [deq_pkg::DATA_WIDTH-1:0] value_ff;
   logic [deq_pkg::ADDR_W-1:0]     head_ff;
   logic [deq_pkg::ADDR_W-1:0]     head_in;
   logic [deq_pkg::COUNT_W-1:0]    count_ff;
   logic [deq_pkg::COUNT_W-1:0]    count_in;
   logic                           err_ff;
   logic                           err_in;
   logic [deq_pkg::DATA_WIDTH-1:0] front_ff;
   logic [deq_pkg::DATA_WIDTH-1:0] back_ff;

   logic                           is_push;
   logic                           is_pop;
   logic                           empty;
   logic                           full;
   logic                           wr_en;
   logic [deq_pkg::ADDR_W-1:0]     wr_addr;
   logic [deq_pkg::ADDR_W-1:0]     head_dec;
   logic [deq_pkg::ADDR_W-1:0]     head_inc;
   logic [deq_pkg::SUM_W-1:0]      tail_sum;
   logic [deq_pkg::SUM_W-1:0]      last_sum;
   logic [deq_pkg::ADDR_W-1:0]     tail_addr;
   logic [deq_pkg::ADDR_W-1:0]     last_addr;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == deq_pkg::COUNT_W'(deq_pkg::DEPTH));

   assign is_push = (op_ff == deq_pkg::OP_PUSH_FRONT) || (op_ff == deq_pkg::OP_PUSH_BACK);
   assign is_pop  = (op_ff == deq_pkg::OP_POP_FRONT) || (op_ff == deq_pkg::OP_POP_BACK);

   assign head_dec = (head_ff == '0) ? deq_pkg::ADDR_W'(deq_pkg::DEPTH - 1)
                                     : head_ff - deq_pkg::ADDR_W'(1);
   assign head_inc = (head_ff == deq_pkg::ADDR_W'(deq_pkg::DEPTH - 1)) ? '0
                                     : head_ff + deq_pkg::ADDR_W'(1);

   // wrap head + count into the ring
   always_comb begin
      tail_sum = deq_pkg::SUM_W'(head_ff) + deq_pkg::SUM_W'(count_ff);
      if (tail_sum >= deq_pkg::SUM_W'(deq_pkg::DEPTH)) begin
         tail_addr = deq_pkg::ADDR_W'(tail_sum - deq_pkg::SUM_W'(deq_pkg::DEPTH));
      end else begin
         tail_addr = deq_pkg::ADDR_W'(tail_sum);
      end
      last_sum = tail_sum - deq_pkg::SUM_W'(1);
      if (empty) begin
         last_addr = head_ff;
      end else if (last_sum >= deq_pkg::SUM_W'(deq_pkg::DEPTH)) begin
         last_addr = deq_pkg::ADDR_W'(last_sum - deq_pkg::SUM_W'(deq_pkg::DEPTH));
      end else begin
         last_addr = deq_pkg::ADDR_W'(last_sum);
      end
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      err_in   = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = tail_addr;
      priority if (is_push && full) begin
         err_in = 1'b1;
      end else if (is_pop && empty) begin
         err_in = 1'b1;
      end else if (op_ff == deq_pkg::OP_PUSH_FRONT) begin
         head_in  = head_dec;
         count_in = count_ff + deq_pkg::COUNT_W'(1);
         wr_en    = 1'b1;
         wr_addr  = head_dec;
      end else if (op_ff == deq_pkg::OP_PUSH_BACK) begin
         count_in = count_ff + deq_pkg::COUNT_W'(1);
         wr_en    = 1'b1;
      end else if (op_ff == deq_pkg::OP_POP_FRONT) begin
         head_in  = head_inc;
         count_in = count_ff - deq_pkg::COUNT_W'(1);
      end else if (op_ff == deq_pkg::OP_POP_BACK) begin
         count_in = count_ff - deq_pkg::COUNT_W'(1);
      end else begin
         err_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_op;
         value_ff <= req_push_value[deq_pkg::DATA_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         err_ff   <= 1'b0;
      end else if (cmd.exec) begin
         head_ff  <= head_in;
         count_ff <= count_in;
         err_ff   <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en) begin
         mem[wr_addr] <= value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         front_ff <= mem[head_ff];
         back_ff  <= mem[last_addr];
      end
   end

   assign rsp_front_value = empty ? '0 : deq_pkg::WORD_W'(front_ff);
   assign rsp_back_value  = empty ? '0 : deq_pkg::WORD_W'(back_ff);
   assign rsp_occupancy   = count_ff;
   assign rsp_is_empty    = empty;
   assign rsp_is_full     = full;
   assign rsp_op_error    = err_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= deq_pkg::COUNT_W'(deq_pkg::DEPTH))
      else $error("entry count beyond depth");

   a_head_range: assert property (@(posedge clock) disable iff (reset)
      head_ff <= deq_pkg::ADDR_W'(deq_pkg::DEPTH - 1))
      else $error("head pointer outside ring");

   a_error_holds: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && err_in) |=> ($stable(count_ff) && $stable(head_ff)))
      else $error("rejected word changed queue state");

endmodule

>>> rtl/core/double_ended_queue_unit.sv
// ----------------------------------------------------------------------------
// Double-ended queue unit
// Ring-buffer deque of 64 entries with push and pop at either end.
// ----------------------------------------------------------------------------
// Each word passes through execute (pointer update and memory write),
// memory read of front and back, then response. The response is shown for
// one cycle on rsp_strobe and cannot be stalled; busy is low during that
// cycle, so a new word may be started alongside it. No word is taken during
// execute or memory read: single-ported write, then registered two-port read
// of the entry memory. Bad pushes and pops set rsp_op_error.
module double_ended_queue_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [deq_pkg::OP_W-1:0]          req_op,
   input  logic [deq_pkg::WORD_W-1:0]        req_push_value,
   output logic                              rsp_strobe,
   output logic [deq_pkg::WORD_W-1:0]        rsp_front_value,
   output logic [deq_pkg::WORD_W-1:0]        rsp_back_value,
   output logic [deq_pkg::COUNT_W-1:0]       rsp_occupancy,
   output logic                              rsp_is_empty,
   output logic                              rsp_is_full,
   output logic                              rsp_op_error
);

   deq_pkg::cmd_type cmd;

   deq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   deq_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_op          (req_op),
      .req_push_value  (req_push_value),
      .rsp_front_value (rsp_front_value),
      .rsp_back_value  (rsp_back_value),
      .rsp_occupancy   (rsp_occupancy),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full),
      .rsp_op_error    (rsp_op_error)
   );

endmodule

>>> verif/deq_status_board_pkg.sv
// ----------------------------------------------------------------------------
// Deque status board
// Tracks the ring-buffer contents, head and count as words are accepted,
// forms the status word each one should return, and checks returned status
// words field by field in arrival order.
// ----------------------------------------------------------------------------
package deq_tb_pkg;

   import deq_pkg::*;

   localparam logic [OP_W-1:0]   OP_LAST   = '1;
   localparam logic [WORD_W-1:0] DATA_MASK = {WORD_W{1'b1}} >> (WORD_W - DATA_WIDTH);

   typedef struct packed {
      logic [WORD_W-1:0]  front_value;
      logic [WORD_W-1:0]  back_value;
      logic [COUNT_W-1:0] occupancy;
      logic               is_empty;
      logic               is_full;
      logic               op_error;
   } deq_status_type;

   class deq_status_board;
      logic [WORD_W-1:0] entries [DEPTH];
      int                head;
      int                count;
      deq_status_type    awaited [$];
      int                failures;
      int                checked;
      int                full_rejects;
      int                empty_rejects;

      function new();
         head          = 0;
         count         = 0;
         failures      = 0;
         checked       = 0;
         full_rejects  = 0;
         empty_rejects = 0;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function void note_word(logic [OP_W-1:0] op, logic [WORD_W-1:0] value);
         deq_status_type want;
         want = '0;
         case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
               if (count >= DEPTH) begin
                  want.op_error = 1'b1;
                  full_rejects++;
               end else if (op == OP_PUSH_FRONT) begin
                  head          = (head + DEPTH - 1) % DEPTH;
                  entries[head] = value & DATA_MASK;
                  count++;
               end else begin
                  entries[(head + count) % DEPTH] = value & DATA_MASK;
                  count++;
               end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
               if (count == 0) begin
                  want.op_error = 1'b1;
                  empty_rejects++;
               end else begin
                  if (op == OP_POP_FRONT)
                     head = (head + 1) % DEPTH;
                  count--;
               end
            end
            default: ;
         endcase
         if (count != 0) begin
            want.front_value = entries[head];
            want.back_value  = entries[(head + count - 1) % DEPTH];
         end
         want.occupancy = COUNT_W'(count);
         want.is_empty  = (count == 0);
         want.is_full   = (count >= DEPTH);
         awaited.push_back(want);
      endfunction

      function void compare(string field, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
         if (got !== want) begin
            failures++;
            $display("%0t %s mismatch: expected %h actual %h", $time, field, want, got);
         end
      endfunction

      function void check_status(deq_status_type got);
         deq_status_type want;
         if (awaited.size() == 0) begin
            failures++;
            $display("%0t unexpected status word: expected none actual %h", $time, got);
            return;
         end
         want = awaited.pop_front();
         checked++;
         compare("front_value", want.front_value, got.front_value);
         compare("back_value", want.back_value, got.back_value);
         compare("occupancy", WORD_W'(want.occupancy), WORD_W'(got.occupancy));
         compare("is_empty", WORD_W'(want.is_empty), WORD_W'(got.is_empty));
         compare("is_full", WORD_W'(want.is_full), WORD_W'(got.is_full));
         compare("op_error", WORD_W'(want.op_error), WORD_W'(got.op_error));
      endfunction
   endclass

endpackage

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// Double-ended queue unit testbench
// Drives directed corner words and then runs of fill, drain and mixed
// traffic with random idle gaps, predicting each status word and checking
// it against the unit's response strobe.
// ----------------------------------------------------------------------------
module tb;

   timeunit 1ns;
   timeprecision 1ps;

   import deq_pkg::*;
   import deq_tb_pkg::*;

   localparam int RANDOM_WORDS = 1630;
   localparam int CYCLE_LIMIT  = 200000;

   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               start          = 1'b0;
   logic [OP_W-1:0]    req_op         = OP_NOP;
   logic [WORD_W-1:0]  req_push_value = '0;
   logic               busy;
   logic               rsp_strobe;
   logic [WORD_W-1:0]  rsp_front_value;
   logic [WORD_W-1:0]  rsp_back_value;
   logic [COUNT_W-1:0] rsp_occupancy;
   logic               rsp_is_empty;
   logic               rsp_is_full;
   logic               rsp_op_error;

   deq_status_board board = new();
   int              words_sent  = 0;
   int              cycle_count = 0;
   bit              idling_on   = 1'b1;

   double_ended_queue_unit dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_push_value  (req_push_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_front_value (rsp_front_value),
      .rsp_back_value  (rsp_back_value),
      .rsp_occupancy   (rsp_occupancy),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full),
      .rsp_op_error    (rsp_op_error)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1)
         board.check_status(deq_status_type'{rsp_front_value, rsp_back_value, rsp_occupancy,
                                             rsp_is_empty, rsp_is_full, rsp_op_error});
   end

   task automatic send_word(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] value);
      req_op         <= op;
      req_push_value <= value;
      start          <= 1'b1;
      @(posedge clock);
      while (busy !== 1'b0)
         @(posedge clock);
      board.note_word(op, value);
      words_sent++;
   endtask

   task automatic hold_off(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic maybe_idle();
      if (idling_on && $urandom_range(99) < 19)
         hold_off($urandom_range(1, 5));
   endtask

   task automatic drain_all();
      start <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0)
         @(posedge clock);
   endtask

   function automatic logic [WORD_W-1:0] pick_value();
      int r;
      r = $urandom_range(99);
      if (r < 8)
         return '1;
      if (r < 16)
         return '0;
      if (r < 24)
         return WORD_W'(1) << $urandom_range(WORD_W - 1);
      return {$urandom, $urandom};
   endfunction

   function automatic logic [OP_W-1:0] pick_op(input int mode);
      int r;
      r = $urandom_range(99);
      if (r >= 94)
         return OP_W'($urandom_range(OP_NOP, OP_LAST));
      case (mode)
         0: r = (r < 80) ? 0 : 1;
         1: r = (r < 75) ? 1 : 0;
         default: r = (r < 47) ? 0 : 1;
      endcase
      if (r == 0)
         return $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      return $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
   endfunction

   initial begin
      int mode;
      int run_left;
      int n;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_word(OP_POP_FRONT, '1);
      send_word(OP_POP_BACK, '0);
      for (int c = OP_NOP; c <= OP_LAST; c++) begin
         maybe_idle();
         send_word(OP_W'(c), {$urandom, $urandom});
      end
      send_word(OP_PUSH_FRONT, '1);
      send_word(OP_PUSH_BACK, '0);
      maybe_idle();
      send_word(OP_PUSH_FRONT, 64'h8000_0000_0000_0001);
      send_word(OP_PUSH_BACK, 64'h5555_5555_5555_5555);
      send_word(OP_PUSH_BACK, 64'hAAAA_AAAA_AAAA_AAAA);
      send_word(OP_NOP, '1);
      send_word(OP_POP_FRONT, '0);
      maybe_idle();
      send_word(OP_POP_BACK, '0);
      send_word(OP_POP_FRONT, '0);
      send_word(OP_POP_BACK, '0);
      send_word(OP_POP_BACK, '0);
      send_word(OP_POP_FRONT, '0);
      send_word(OP_PUSH_BACK, 64'h0123_4567_89AB_CDEF);
      send_word(OP_POP_FRONT, '0);

      run_left = 0;
      mode     = 0;
      for (n = 0; n < RANDOM_WORDS; n++) begin
         if (run_left == 0) begin
            mode     = $urandom_range(2);
            run_left = $urandom_range(40, 150);
         end
         run_left--;
         idling_on = !(n >= 700 && n < 1000);
         if (n == 400 || n == 1250)
            drain_all();
         maybe_idle();
         send_word(pick_op(mode), pick_value());
      end

      drain_all();
      repeat (10) @(posedge clock);

      $display("covered %0d words with %0d status words checked", words_sent, board.checked);
      $display("rejected %0d pushes at full and %0d pops at empty",
               board.full_rejects, board.empty_rejects);
      if (board.failures == 0 && board.pending() == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/deq_pkg.sv
rtl/core/deq_ctrl.sv
rtl/core/deq_datapath.sv
rtl/core/double_ended_queue_unit.sv
verif/deq_status_board_pkg.sv
verif/tb.sv
